[hw/rtl/tcsw_pkg.sv]
// shared constants, codes and payload types for the text console writer
// no dependencies
`default_nettype none

package tcsw_pkg;

	localparam int COLUMNS    = 80;
	localparam int ROWS       = 25;
	localparam int CELL_COUNT = ROWS * COLUMNS;
	localparam int BOTTOM     = (ROWS - 1) * COLUMNS;
	localparam int CELL_W     = $clog2(CELL_COUNT);
	localparam int COL_W      = $clog2(COLUMNS);
	localparam int ROW_W      = $clog2(ROWS);

	localparam int MODE_W = 2;
	localparam int CHAR_W = 8;
	localparam int IDX_W  = 11;
	localparam int POS_W  = 11;
	localparam int WORD_W = 16;

	localparam logic [CHAR_W-1:0] ATTR_RESET      = 8'h07;
	localparam logic [CHAR_W-1:0] CHAR_NEWLINE    = 8'h0a;
	localparam logic [CHAR_W-1:0] CHAR_SPACE      = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_UNDERSCORE = 8'h5f;

	localparam logic [MODE_W-1:0] MODE_PUT   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 2'd1;
	localparam logic [MODE_W-1:0] MODE_BLINK = 2'd2;
	localparam logic [MODE_W-1:0] MODE_READ  = 2'd3;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CHAR_W-1:0] char_code;
		logic [IDX_W-1:0]  cell_index;
	} cmd_t;

	typedef struct packed {
		logic [POS_W-1:0]  cursor_pos;
		logic [WORD_W-1:0] cell_data;
	} res_t;

endpackage

`default_nettype wire

[hw/rtl/tcsw_screen_ram.sv]
// screen store: one write port, one read port with registered read data
// depends on tcsw_pkg
`default_nettype none

module tcsw_screen_ram (
	input  wire logic                        clk,
	input  wire logic                        we,
	input  wire logic [tcsw_pkg::CELL_W-1:0] waddr,
	input  wire logic [tcsw_pkg::WORD_W-1:0] wdata,
	input  wire logic                        re,
	input  wire logic [tcsw_pkg::CELL_W-1:0] raddr,
	output logic      [tcsw_pkg::WORD_W-1:0] rdata
);
	import tcsw_pkg::*;

	logic [WORD_W-1:0] mem [CELL_COUNT];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/text_console_scroll_writer.sv]
// Text console writer over a ROWS x COLUMNS store of attribute/character
// words (80x25). Requests are taken one at a time on cmd and each gives one
// result on res, which is held in an output register so the next request
// may be taken while a result waits. Clear sweeps the whole store one cell
// a cycle, and a put that passes the last row runs a scroll sweep that copies
// and blanks one cell a cycle through the single write port of the store.
// After reset the store is blanked by a pass over every cell during which no
// request is taken; register writes are taken at any time.
// depends on tcsw_pkg and tcsw_screen_ram
`default_nettype none

module text_console_scroll_writer (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [2:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic      [31:0]  prdata,
	output logic              pready,
	input  wire logic         cmd_valid,
	output logic              cmd_ready,
	input  wire tcsw_pkg::cmd_t cmd,
	output logic              res_valid,
	input  wire logic         res_ready,
	output tcsw_pkg::res_t    res
);
	import tcsw_pkg::*;

	localparam logic [2:0] ST_INIT   = 3'd0;
	localparam logic [2:0] ST_IDLE   = 3'd1;
	localparam logic [2:0] ST_EXEC   = 3'd2;
	localparam logic [2:0] ST_RDWAIT = 3'd3;
	localparam logic [2:0] ST_SCROLL = 3'd4;
	localparam logic [2:0] ST_CLEAR  = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0]        state_q;
	logic [CHAR_W-1:0] attr_q;
	cmd_t              cmd_q;
	logic [COL_W-1:0]  col_q;
	logic [ROW_W-1:0]  row_q;
	logic [CELL_W-1:0] idx_q;
	logic              shown_q;
	logic [CELL_W-1:0] ptr_q;
	logic              rd_ok_q;
	logic [WORD_W-1:0] data_q;
	logic              res_valid_q;
	res_t              res_q;

	logic              mem_we;
	logic [CELL_W-1:0] mem_waddr;
	logic [WORD_W-1:0] mem_wdata;
	logic              mem_re;
	logic [CELL_W-1:0] mem_raddr;
	logic [WORD_W-1:0] mem_rdata;

	logic              is_nl;
	logic              wrap;
	logic              ovf;
	logic [COL_W-1:0]  col_n;
	logic [ROW_W-1:0]  row_n;
	logic [CELL_W-1:0] idx_n;
	logic              sweep_last;
	logic [CELL_W:0]   scroll_src;
	logic              rd_in_range;
	logic [CELL_W+IDX_W-1:0] rd_idx_ext;
	logic [CELL_W+POS_W-1:0] pos_ext;
	logic              fin_go;
	logic [CELL_W-1:0] fin_idx;
	logic [WORD_W-1:0] fin_data;
	logic              slot_free;
	logic              cfg_we;
	logic [WORD_W-1:0] blank;

	// config port
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite && !paddr[2];
	assign prdata = paddr[2] ? 32'd0 : {24'd0, attr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= ATTR_RESET;
		end else if (cfg_we) begin
			attr_q <= pwdata[CHAR_W-1:0];
		end
	end

	assign blank = {attr_q, CHAR_SPACE};

	// cursor advance for a put
	assign is_nl = (cmd_q.char_code == CHAR_NEWLINE);
	assign wrap  = is_nl || (col_q == COL_W'(COLUMNS - 1));
	assign ovf   = wrap && (row_q == ROW_W'(ROWS - 1));
	assign col_n = wrap ? '0 : col_q + COL_W'(1);
	assign row_n = ovf ? ROW_W'(ROWS - 1) : (wrap ? row_q + ROW_W'(1) : row_q);
	always_comb begin
		if (ovf) begin
			idx_n = CELL_W'(BOTTOM);
		end else if (is_nl) begin
			idx_n = idx_q - CELL_W'(col_q) + CELL_W'(COLUMNS);
		end else begin
			idx_n = idx_q + CELL_W'(1);
		end
	end

	// shared sweep counter compare and scroll source address
	assign sweep_last = (ptr_q == CELL_W'(CELL_COUNT - 1));
	assign scroll_src = {1'b0, ptr_q} + (CELL_W + 1)'(COLUMNS + 1);

	assign rd_idx_ext  = {{CELL_W{1'b0}}, cmd_q.cell_index};
	assign rd_in_range = (rd_idx_ext < (CELL_W + IDX_W)'(CELL_COUNT));

	assign slot_free = !res_valid_q || res_ready;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = ptr_q;
		mem_wdata = blank;
		mem_re    = 1'b0;
		mem_raddr = scroll_src[CELL_W-1:0];
		fin_go    = 1'b0;
		fin_idx   = idx_q;
		fin_data  = data_q;
		unique case (state_q)
			ST_INIT: begin
				mem_we    = 1'b1;
				mem_wdata = {ATTR_RESET, CHAR_SPACE};
			end
			ST_EXEC: begin
				unique case (cmd_q.mode)
					MODE_PUT: begin
						mem_we    = !is_nl;
						mem_waddr = idx_q;
						mem_wdata = {attr_q, cmd_q.char_code};
						// prime the scroll copy with the first cell of row one
						mem_re    = ovf;
						mem_raddr = CELL_W'(COLUMNS);
						fin_go    = !ovf;
						fin_idx   = idx_n;
					end
					MODE_CLEAR: begin
					end
					MODE_BLINK: begin
						mem_we    = 1'b1;
						mem_waddr = idx_q;
						mem_wdata = {attr_q, shown_q ? CHAR_UNDERSCORE : CHAR_SPACE};
						fin_go    = 1'b1;
					end
					MODE_READ: begin
						mem_re    = rd_in_range;
						mem_raddr = rd_idx_ext[CELL_W-1:0];
					end
					default: begin
					end
				endcase
			end
			ST_RDWAIT: begin
				fin_go   = 1'b1;
				fin_data = rd_ok_q ? mem_rdata : '0;
			end
			ST_SCROLL: begin
				mem_we    = 1'b1;
				mem_wdata = (ptr_q < CELL_W'(BOTTOM)) ? mem_rdata : blank;
				mem_re    = (scroll_src < (CELL_W + 1)'(CELL_COUNT));
			end
			ST_CLEAR: begin
				mem_we = 1'b1;
			end
			ST_DONE: begin
				fin_go = 1'b1;
			end
			default: begin
			end
		endcase
	end

	tcsw_screen_ram u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign cmd_ready = (state_q == ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			ptr_q   <= '0;
			col_q   <= '0;
			row_q   <= '0;
			idx_q   <= '0;
			shown_q <= 1'b1;
			rd_ok_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_INIT: begin
					if (sweep_last) begin
						ptr_q   <= '0;
						state_q <= ST_IDLE;
					end else begin
						ptr_q <= ptr_q + CELL_W'(1);
					end
				end
				ST_IDLE: begin
					if (cmd_valid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					unique case (cmd_q.mode)
						MODE_PUT: begin
							col_q <= col_n;
							row_q <= row_n;
							idx_q <= idx_n;
							if (ovf) begin
								ptr_q   <= '0;
								state_q <= ST_SCROLL;
							end else begin
								state_q <= slot_free ? ST_IDLE : ST_DONE;
							end
						end
						MODE_CLEAR: begin
							col_q   <= '0;
							row_q   <= '0;
							idx_q   <= '0;
							ptr_q   <= '0;
							state_q <= ST_CLEAR;
						end
						MODE_BLINK: begin
							shown_q <= !shown_q;
							state_q <= slot_free ? ST_IDLE : ST_DONE;
						end
						MODE_READ: begin
							rd_ok_q <= rd_in_range;
							state_q <= ST_RDWAIT;
						end
						default: begin
						end
					endcase
				end
				ST_SCROLL, ST_CLEAR: begin
					if (sweep_last) begin
						ptr_q   <= '0;
						state_q <= ST_DONE;
					end else begin
						ptr_q <= ptr_q + CELL_W'(1);
					end
				end
				ST_RDWAIT, ST_DONE: begin
					state_q <= slot_free ? ST_IDLE : ST_DONE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// request capture and pending result data
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q  <= cmd;
			data_q <= '0;
		end else if (fin_go) begin
			data_q <= fin_data;
		end
	end

	assign pos_ext = {{POS_W{1'b0}}, fin_idx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fin_go && slot_free) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go && slot_free) begin
			res_q.cursor_pos <= pos_ext[POS_W-1:0];
			res_q.cell_data  <= fin_data;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// cursor stays on the screen
	assert property (@(posedge clk) disable iff (!arst_n)
		(int'(col_q) < COLUMNS) && (int'(row_q) < ROWS))
		else $error("cursor outside the screen");

	// linear cursor index tracks row and column
	assert property (@(posedge clk) disable iff (!arst_n)
		int'(idx_q) == int'(row_q) * COLUMNS + int'(col_q))
		else $error("cursor index out of step with row and column");

	// one request at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("request taken while another is in work");

	// store is never written while waiting for a request
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !mem_we)
		else $error("store written while idle");

	// a result is only produced when the output register can take it
	assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=> $stable(res))
		else $error("pending result overwritten");

endmodule

`default_nettype wire
